// ===== sv/coprocessor_regs_with_strided_dma_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the coprocessor register block
// Shared property shapes, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COPROCESSOR_REGS_WITH_STRIDED_DMA_MACROS_SVH
`define COPROCESSOR_REGS_WITH_STRIDED_DMA_MACROS_SVH

// Condition holds at every edge out of reset.
`define CRSD_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CRSD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define CRSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/crsd_pkg.sv =====
// ----------------------------------------------------------------------------
// crsd_pkg
// Types, register map and result codes of the coprocessor register block.
// ----------------------------------------------------------------------------
`default_nettype none

package crsd_pkg;

  // Bus operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [3:0] WORD_BYTES = 4'd4;

  // Result kinds
  localparam logic [2:0] KIND_DONE      = 3'd0;
  localparam logic [2:0] KIND_BAD_SIZE  = 3'd1;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd2;
  localparam logic [2:0] KIND_SET_INTR  = 3'd3;
  localparam logic [2:0] KIND_LINE      = 3'd4;
  localparam logic [2:0] KIND_ABORT     = 3'd5;
  localparam logic [2:0] KIND_IDLE_TICK = 3'd6;

  // Register map
  localparam logic [31:0] ADDR_MEM    = 32'h0404_0000;
  localparam logic [31:0] ADDR_DRAM   = 32'h0404_0004;
  localparam logic [31:0] ADDR_RLEN   = 32'h0404_0008;
  localparam logic [31:0] ADDR_WLEN   = 32'h0404_000c;
  localparam logic [31:0] ADDR_STATUS = 32'h0404_0010;
  localparam logic [31:0] ADDR_FULL   = 32'h0404_0014;
  localparam logic [31:0] ADDR_BUSY   = 32'h0404_0018;
  localparam logic [31:0] ADDR_SEMA   = 32'h0404_001c;
  localparam logic [31:0] ADDR_PC     = 32'h0408_0000;
  localparam logic [31:0] ADDR_BIST   = 32'h0408_0004;

  // Memory sizes for the DMA range check
  localparam logic [25:0] DRAM_BYTES      = 26'd4194304;
  localparam logic [13:0] LOCAL_MEM_BYTES = 14'd4096;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [3:0] {
    REG_MEM, REG_DRAM, REG_RLEN, REG_WLEN, REG_STATUS,
    REG_FULL, REG_BUSY, REG_SEMA, REG_PC, REG_BIST
  } reg_sel_t;

  typedef enum logic [2:0] {
    CMD_READ, CMD_WRITE, CMD_TICK, CMD_IDLE, CMD_BAD_SIZE, CMD_UNKNOWN
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  access_bytes;
    logic [31:0] address;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] read_data;
    logic        clear_interrupt;
    logic        pc_jump;
    logic [23:0] line_dram_address;
    logic [11:0] line_mem_address;
    logic        line_imem;
    logic [12:0] line_length;
    logic        line_to_dram;
  } out_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    reg_sel_t    sel;
    logic [31:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/crsd_front.sv =====
// ----------------------------------------------------------------------------
// crsd_front
// Accepts bus transactions and classifies them into back-end commands.
// ----------------------------------------------------------------------------
`default_nettype none

module crsd_front
  import crsd_pkg::*;
(
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  input  wire logic q_full,
  output logic      q_push,
  output cmd_t      q_cmd
);

  logic     hit;
  reg_sel_t sel;

  always_comb begin
    hit = 1'b1;
    sel = REG_MEM;
    case (in_data.address)
      ADDR_MEM:    sel = REG_MEM;
      ADDR_DRAM:   sel = REG_DRAM;
      ADDR_RLEN:   sel = REG_RLEN;
      ADDR_WLEN:   sel = REG_WLEN;
      ADDR_STATUS: sel = REG_STATUS;
      ADDR_FULL:   sel = REG_FULL;
      ADDR_BUSY:   sel = REG_BUSY;
      ADDR_SEMA:   sel = REG_SEMA;
      ADDR_PC:     sel = REG_PC;
      ADDR_BIST:   sel = REG_BIST;
      default:     hit = 1'b0;
    endcase
  end

  // Ticks and idle ops ahead of size check, size check ahead of address decode
  always_comb begin
    q_cmd.sel  = sel;
    q_cmd.data = in_data.write_data;
    if (in_data.opcode == OP_TICK) begin
      q_cmd.kind = CMD_TICK;
    end else if (in_data.opcode == OP_NONE) begin
      q_cmd.kind = CMD_IDLE;
    end else if (in_data.access_bytes != WORD_BYTES) begin
      q_cmd.kind = CMD_BAD_SIZE;
    end else if (!hit) begin
      q_cmd.kind = CMD_UNKNOWN;
    end else if (in_data.opcode == OP_READ) begin
      q_cmd.kind = CMD_READ;
    end else begin
      q_cmd.kind = CMD_WRITE;
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

// ===== sv/crsd_queue.sv =====
// ----------------------------------------------------------------------------
// crsd_queue
// Short command FIFO decoupling the front classifier from the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "coprocessor_regs_with_strided_dma_macros.svh"

module crsd_queue
  import crsd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd   = store_r[rd_ptr_r];
  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);

  `CRSD_ASSERT_HOLDS(a_cnt_bound, count_r <= CNT_W'(DEPTH), "queue count above depth")
  `CRSD_ASSERT_IMPLIES(a_pop_nonempty, pop, count_r != '0, "pop from empty queue")
  `CRSD_ASSERT_NEXT(a_cnt_inc, push && !pop, count_r == $past(count_r) + CNT_W'(1), "count did not rise")

endmodule

`default_nettype wire

// ===== sv/crsd_back.sv =====
// ----------------------------------------------------------------------------
// crsd_back
// Register file, status logic and strided DMA sequencer with result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "coprocessor_regs_with_strided_dma_macros.svh"

module crsd_back
  import crsd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic [12:0] mem_addr_r,  mem_addr_nxt;
  logic [23:0] dram_addr_r, dram_addr_nxt;
  logic [31:0] rlen_r,      rlen_nxt;
  logic [31:0] wlen_r,      wlen_nxt;
  logic [11:0] status_r,    status_nxt;
  logic        sema_r,      sema_nxt;
  logic [11:0] pc_r,        pc_nxt;
  logic [31:0] bist_r,      bist_nxt;
  logic        dma_active_r, dma_active_nxt;
  logic [8:0]  lines_left_r, lines_left_nxt;
  logic [24:0] dram_cur_r,   dram_cur_nxt;
  logic [12:0] mem_cur_r,    mem_cur_nxt;
  logic [12:0] line_bytes_r, line_bytes_nxt;
  logic [11:0] skip_r,       skip_nxt;
  logic        dir_r,        dir_nxt;
  logic        bank_r,       bank_nxt;
  logic        out_valid_r,  out_valid_nxt;
  out_t        out_r,        out_nxt;

  logic [25:0] dram_end;
  logic [13:0] mem_end;
  logic        arm;
  logic        arm_dir;

  // Clear bits first, then set bits, so set wins
  function automatic logic [11:0] status_upd(input logic [11:0] f, input logic [31:0] v);
    logic [11:0] r;
    r = f;
    if (v[0]) r[0] = 1'b0;
    if (v[1]) r[0] = 1'b1;
    if (v[2]) r[1] = 1'b0;
    if (v[5]) r[2] = 1'b0;
    if (v[6]) r[2] = 1'b1;
    if (v[7]) r[3] = 1'b0;
    if (v[8]) r[3] = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (v[9 + 2 * k])  r[4 + k] = 1'b0;
      if (v[10 + 2 * k]) r[4 + k] = 1'b1;
    end
    return r;
  endfunction

  assign dram_end = {1'b0, dram_cur_r} + 26'(line_bytes_r);
  assign mem_end  = {1'b0, mem_cur_r} + 14'(line_bytes_r);

  always_comb begin
    mem_addr_nxt   = mem_addr_r;
    dram_addr_nxt  = dram_addr_r;
    rlen_nxt       = rlen_r;
    wlen_nxt       = wlen_r;
    status_nxt     = status_r;
    sema_nxt       = sema_r;
    pc_nxt         = pc_r;
    bist_nxt       = bist_r;
    dma_active_nxt = dma_active_r;
    lines_left_nxt = lines_left_r;
    dram_cur_nxt   = dram_cur_r;
    mem_cur_nxt    = mem_cur_r;
    line_bytes_nxt = line_bytes_r;
    skip_nxt       = skip_r;
    dir_nxt        = dir_r;
    bank_nxt       = bank_r;
    arm            = 1'b0;
    arm_dir        = 1'b0;
    out_nxt        = out_r;
    q_pop          = q_valid && (!out_valid_r || out_ready);
    out_valid_nxt  = q_pop || (out_valid_r && !out_ready);

    if (q_pop) begin
      out_nxt = '0;
      case (q_cmd.kind)
        CMD_TICK: begin
          if (!dma_active_r) begin
            out_nxt.result_kind = KIND_IDLE_TICK;
          end else if (dram_end > DRAM_BYTES || mem_end > LOCAL_MEM_BYTES) begin
            out_nxt.result_kind = KIND_ABORT;
            dma_active_nxt      = 1'b0;
            lines_left_nxt      = '0;
          end else begin
            out_nxt.result_kind       = KIND_LINE;
            out_nxt.line_dram_address = dram_cur_r[23:0];
            out_nxt.line_mem_address  = mem_cur_r[11:0];
            out_nxt.line_imem         = bank_r;
            out_nxt.line_length       = line_bytes_r;
            out_nxt.line_to_dram      = dir_r;
            dram_cur_nxt   = dram_cur_r + 25'(line_bytes_r) + 25'(skip_r);
            mem_cur_nxt    = mem_cur_r + line_bytes_r;
            lines_left_nxt = lines_left_r - 9'd1;
            if (lines_left_r == 9'd1) begin
              dma_active_nxt = 1'b0;
            end
          end
        end
        CMD_IDLE:     out_nxt.result_kind = KIND_IDLE_TICK;
        CMD_BAD_SIZE: out_nxt.result_kind = KIND_BAD_SIZE;
        CMD_UNKNOWN:  out_nxt.result_kind = KIND_UNKNOWN;
        CMD_READ: begin
          out_nxt.result_kind = KIND_DONE;
          case (q_cmd.sel)
            REG_MEM:    out_nxt.read_data = 32'(mem_addr_r);
            REG_DRAM:   out_nxt.read_data = 32'(dram_addr_r);
            REG_RLEN:   out_nxt.read_data = rlen_r;
            REG_WLEN:   out_nxt.read_data = wlen_r;
            REG_STATUS: out_nxt.read_data = {17'd0, status_r[11:4], status_r[3],
                                             status_r[2], 3'd0, status_r[1:0]};
            REG_SEMA: begin
              out_nxt.read_data = 32'(sema_r);
              sema_nxt          = 1'b1;
            end
            REG_PC:     out_nxt.read_data = 32'(pc_r);
            REG_BIST:   out_nxt.read_data = bist_r;
            default:    out_nxt.read_data = '0;
          endcase
        end
        CMD_WRITE: begin
          out_nxt.result_kind = KIND_DONE;
          case (q_cmd.sel)
            REG_MEM:  mem_addr_nxt  = q_cmd.data[12:0];
            REG_DRAM: dram_addr_nxt = q_cmd.data[23:0];
            REG_RLEN: begin
              rlen_nxt = q_cmd.data;
              arm      = 1'b1;
              arm_dir  = 1'b0;
            end
            REG_WLEN: begin
              wlen_nxt = q_cmd.data;
              arm      = 1'b1;
              arm_dir  = 1'b1;
            end
            REG_STATUS: begin
              status_nxt              = status_upd(status_r, q_cmd.data);
              out_nxt.clear_interrupt = q_cmd.data[3];
              if (q_cmd.data[4]) begin
                out_nxt.result_kind = KIND_SET_INTR;
              end
            end
            REG_SEMA: sema_nxt = 1'b0;
            REG_PC: begin
              pc_nxt          = q_cmd.data[11:0];
              out_nxt.pc_jump = 1'b1;
            end
            REG_BIST: bist_nxt = q_cmd.data;
            default: ;
          endcase
        end
        default: out_nxt.result_kind = KIND_IDLE_TICK;
      endcase
    end

    // Arm a DMA from the length word and the current address registers
    if (arm) begin
      line_bytes_nxt = {1'b0, q_cmd.data[11:3], 3'b111} + 13'd1;
      lines_left_nxt = {1'b0, q_cmd.data[19:12]} + 9'd1;
      skip_nxt       = q_cmd.data[31:20];
      dram_cur_nxt   = {1'b0, dram_addr_r};
      mem_cur_nxt    = {1'b0, mem_addr_r[11:0]};
      bank_nxt       = mem_addr_r[12];
      dir_nxt        = arm_dir;
      dma_active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_addr_r   <= '0;
      dram_addr_r  <= '0;
      rlen_r       <= '0;
      wlen_r       <= '0;
      status_r     <= '0;
      sema_r       <= 1'b0;
      pc_r         <= '0;
      bist_r       <= '0;
      dma_active_r <= 1'b0;
      lines_left_r <= '0;
      dram_cur_r   <= '0;
      mem_cur_r    <= '0;
      line_bytes_r <= '0;
      skip_r       <= '0;
      dir_r        <= 1'b0;
      bank_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      mem_addr_r   <= mem_addr_nxt;
      dram_addr_r  <= dram_addr_nxt;
      rlen_r       <= rlen_nxt;
      wlen_r       <= wlen_nxt;
      status_r     <= status_nxt;
      sema_r       <= sema_nxt;
      pc_r         <= pc_nxt;
      bist_r       <= bist_nxt;
      dma_active_r <= dma_active_nxt;
      lines_left_r <= lines_left_nxt;
      dram_cur_r   <= dram_cur_nxt;
      mem_cur_r    <= mem_cur_nxt;
      line_bytes_r <= line_bytes_nxt;
      skip_r       <= skip_nxt;
      dir_r        <= dir_nxt;
      bank_r       <= bank_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `CRSD_ASSERT_HOLDS(a_active_lines, dma_active_r == (lines_left_r != '0), "DMA flag and line count disagree")
  `CRSD_ASSERT_IMPLIES(a_line_len, out_valid_r && out_r.result_kind == KIND_LINE, out_r.line_length[2:0] == 3'b000 && out_r.line_length != '0, "bad DMA line length")
  `CRSD_ASSERT_IMPLIES(a_jump_done, out_valid_r && out_r.pc_jump, out_r.result_kind == KIND_DONE, "PC jump on a failed write")

endmodule

`default_nettype wire

// ===== sv/coprocessor_regs_with_strided_dma.sv =====
// ----------------------------------------------------------------------------
// coprocessor_regs_with_strided_dma
// Bus register block of a signal coprocessor with a strided line DMA engine.
// ----------------------------------------------------------------------------
// Each input transaction is a 32-bit register read, a register write, a DMA
// tick or a no-op, and each one yields exactly one result transaction, in
// order. The front end decodes the opcode, access size and address into a
// command and drops it into a short FIFO (QUEUE_DEPTH entries); while the
// result register is free or being taken, the back end pops one command per
// cycle, updates the registers and DMA cursors and loads the result register.
// Sustained rate is one transaction per clock while out_ready stays high. The
// edge that accepts an input transaction writes it into the FIFO; the back
// end then pops it and loads the result register, which raises out_valid.
// When out_ready is held low the result register holds, the FIFO fills and
// in_ready drops once QUEUE_DEPTH commands are waiting. A write to either
// length register arms a DMA of count+1 lines of (length|7)+1 bytes; each tick
// then hands out one line descriptor, or ends the DMA with a range abort when
// the line would pass the end of DRAM (checked first) or of local memory.
// ----------------------------------------------------------------------------
`default_nettype none

module coprocessor_regs_with_strided_dma
  import crsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // input transactions
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  // result transactions
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  // Front to FIFO
  logic q_push;
  logic q_full;
  cmd_t q_cmd_in;

  // FIFO to back end
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd_out;

  // Classify: tick, idle, bad size, unknown register, read or write
  crsd_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd_in)
  );

  // Hold classified commands so either side can stall on its own
  crsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_cmd_out),
    .not_empty (q_valid)
  );

  // Execute: registers, status, semaphore, DMA sequencing, result register
  crsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/sv/crsd_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsd_tb_pkg
// Result prediction and checking for the coprocessor register block: the
// register file, status flags, semaphore and strided DMA cursors are mirrored
// here, and each accepted request queues the result it must produce.
// ----------------------------------------------------------------------------
package crsd_tb_pkg;
  import crsd_pkg::*;

  class crsd_result_board;
    // mirrored registers
    logic [12:0] mem_addr_q;
    logic [23:0] dram_addr_q;
    logic [31:0] rd_len_q;
    logic [31:0] wr_len_q;
    logic [11:0] flags_q;
    logic        sema_q;
    logic [11:0] pc_q;
    logic [31:0] bist_q;
    // mirrored DMA engine
    logic        dma_on;
    logic [8:0]  lines_todo;
    logic [24:0] dram_pos;
    logic [12:0] mem_pos;
    logic [12:0] line_size;
    logic [11:0] stride_gap;
    logic        to_dram;
    logic        imem_bank;

    out_t        awaited_results[$];
    int unsigned failures;

    function new();
      mem_addr_q  = '0;
      dram_addr_q = '0;
      rd_len_q    = '0;
      wr_len_q    = '0;
      flags_q     = '0;
      sema_q      = 1'b0;
      pc_q        = '0;
      bist_q      = '0;
      dma_on      = 1'b0;
      lines_todo  = '0;
      dram_pos    = '0;
      mem_pos     = '0;
      line_size   = '0;
      stride_gap  = '0;
      to_dram     = 1'b0;
      imem_bank   = 1'b0;
      failures    = 0;
    endfunction

    // Load the DMA cursors from a length word and the current address registers.
    function void arm_dma(logic [31:0] len_word, logic dir);
      line_size  = {1'b0, len_word[11:0] | 12'h007} + 13'd1;
      lines_todo = {1'b0, len_word[19:12]} + 9'd1;
      stride_gap = len_word[31:20];
      dram_pos   = {1'b0, dram_addr_q};
      mem_pos    = {1'b0, mem_addr_q[11:0]};
      imem_bank  = mem_addr_q[12];
      to_dram    = dir;
      dma_on     = 1'b1;
    endfunction

    function void note_request(in_t t);
      out_t        want;
      logic [31:0] dram_end;
      logic [31:0] mem_end;
      want = '0;
      if (t.opcode == OP_TICK || t.opcode == OP_NONE) begin
        dram_end = 32'(dram_pos) + 32'(line_size);
        mem_end  = 32'(mem_pos) + 32'(line_size);
        if (t.opcode == OP_NONE || !dma_on) begin
          want.result_kind = KIND_IDLE_TICK;
        end else if (dram_end > 32'(DRAM_BYTES) || mem_end > 32'(LOCAL_MEM_BYTES)) begin
          want.result_kind = KIND_ABORT;
          dma_on     = 1'b0;
          lines_todo = '0;
        end else begin
          want.result_kind       = KIND_LINE;
          want.line_dram_address = dram_pos[23:0];
          want.line_mem_address  = mem_pos[11:0];
          want.line_imem         = imem_bank;
          want.line_length       = line_size;
          want.line_to_dram      = to_dram;
          dram_pos   = dram_pos + 25'(line_size) + 25'(stride_gap);
          mem_pos    = mem_pos + line_size;
          lines_todo = lines_todo - 9'd1;
          if (lines_todo == '0) dma_on = 1'b0;
        end
      end else if (t.access_bytes != WORD_BYTES) begin
        want.result_kind = KIND_BAD_SIZE;
      end else if (t.opcode == OP_READ) begin
        want.result_kind = KIND_DONE;
        case (t.address)
          ADDR_MEM:    want.read_data = 32'(mem_addr_q);
          ADDR_DRAM:   want.read_data = 32'(dram_addr_q);
          ADDR_RLEN:   want.read_data = rd_len_q;
          ADDR_WLEN:   want.read_data = wr_len_q;
          ADDR_STATUS: want.read_data = {17'd0, flags_q[11:4], flags_q[3], flags_q[2],
                                         3'd0, flags_q[1:0]};
          ADDR_FULL:   want.read_data = '0;
          ADDR_BUSY:   want.read_data = '0;
          ADDR_SEMA: begin
            want.read_data = 32'(sema_q);
            sema_q = 1'b1;
          end
          ADDR_PC:     want.read_data = 32'(pc_q);
          ADDR_BIST:   want.read_data = bist_q;
          default:     want.result_kind = KIND_UNKNOWN;
        endcase
      end else begin
        want.result_kind = KIND_DONE;
        case (t.address)
          ADDR_MEM:  mem_addr_q = t.write_data[12:0];
          ADDR_DRAM: dram_addr_q = t.write_data[23:0];
          ADDR_RLEN: begin
            rd_len_q = t.write_data;
            arm_dma(t.write_data, 1'b0);
          end
          ADDR_WLEN: begin
            wr_len_q = t.write_data;
            arm_dma(t.write_data, 1'b1);
          end
          ADDR_STATUS: begin
            if (t.write_data[0]) flags_q[0] = 1'b0;
            if (t.write_data[1]) flags_q[0] = 1'b1;
            if (t.write_data[2]) flags_q[1] = 1'b0;
            if (t.write_data[5]) flags_q[2] = 1'b0;
            if (t.write_data[6]) flags_q[2] = 1'b1;
            if (t.write_data[7]) flags_q[3] = 1'b0;
            if (t.write_data[8]) flags_q[3] = 1'b1;
            // set wins over clear for the signal bits
            for (int k = 0; k < 8; k++) begin
              if (t.write_data[9 + 2 * k])  flags_q[4 + k] = 1'b0;
              if (t.write_data[10 + 2 * k]) flags_q[4 + k] = 1'b1;
            end
            want.clear_interrupt = t.write_data[3];
            if (t.write_data[4]) want.result_kind = KIND_SET_INTR;
          end
          ADDR_FULL, ADDR_BUSY: ;
          ADDR_SEMA: sema_q = 1'b0;
          ADDR_PC: begin
            pc_q = t.write_data[11:0];
            want.pc_jump = 1'b1;
          end
          ADDR_BIST: bist_q = t.write_data;
          default:   want.result_kind = KIND_UNKNOWN;
        endcase
      end
      awaited_results.push_back(want);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_response(out_t got);
      out_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result transaction with none expected, got %h", $time, got);
        failures++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("clear_interrupt", 32'(want.clear_interrupt), 32'(got.clear_interrupt));
      compare_field("pc_jump", 32'(want.pc_jump), 32'(got.pc_jump));
      compare_field("line_dram_address", 32'(want.line_dram_address),
                    32'(got.line_dram_address));
      compare_field("line_mem_address", 32'(want.line_mem_address),
                    32'(got.line_mem_address));
      compare_field("line_imem", 32'(want.line_imem), 32'(got.line_imem));
      compare_field("line_length", 32'(want.line_length), 32'(got.line_length));
      compare_field("line_to_dram", 32'(want.line_to_dram), 32'(got.line_to_dram));
    endfunction
  endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the coprocessor register block with directed and random bus reads,
// writes and DMA ticks under random idling on both channels, and checks every
// result transaction against the mirrored registers and DMA cursors.
// ----------------------------------------------------------------------------
module testbench;
  import crsd_pkg::*;
  import crsd_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned RANDOM_TXNS = 500;
  localparam int unsigned LONG_HOLD   = 80;
  // margin over the latency through the block
  localparam int unsigned SETTLE      = 12;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  crsd_result_board board;
  int unsigned      sent_txns;
  bit               no_idle;        // stretch with neither side idling
  bit               long_hold_due;  // ask the result side for one long hold-off

  logic [31:0] reg_map [10] = '{ADDR_MEM, ADDR_DRAM, ADDR_RLEN, ADDR_WLEN, ADDR_STATUS,
                                ADDR_FULL, ADDR_BUSY, ADDR_SEMA, ADDR_PC, ADDR_BIST};

  coprocessor_regs_with_strided_dma u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one; none at all during a burst.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t make_txn(logic [1:0] op, logic [3:0] nbytes, logic [31:0] addr,
                                   logic [31:0] data);
    in_t t;
    t.opcode       = op;
    t.access_bytes = nbytes;
    t.address      = addr;
    t.write_data   = data;
    return t;
  endfunction

  // Offer one transaction after a random gap; valid is only dropped when a gap
  // is taken, so back-to-back transactions keep it high across the edge.
  task automatic send_txn(in_t t);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_request(t);
    sent_txns++;
  endtask

  task automatic reg_read(logic [31:0] addr);
    send_txn(make_txn(OP_READ, WORD_BYTES, addr, $urandom));
  endtask

  task automatic reg_write(logic [31:0] addr, logic [31:0] data);
    send_txn(make_txn(OP_WRITE, WORD_BYTES, addr, data));
  endtask

  // Size, address and data of a tick are ignored, so randomise them.
  task automatic dma_tick();
    send_txn(make_txn(OP_TICK, 4'($urandom_range(0, 15)), $urandom, $urandom));
  endtask

  // Withdraw valid and hold until every queued result has been seen.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic random_reg_access();
    logic [31:0] addr;
    addr = reg_map[4'($urandom_range(0, 9))];
    if ($urandom_range(0, 1)) reg_read(addr);
    else reg_write(addr, $urandom);
  endtask

  task automatic noise_txn();
    logic [31:0] addr;
    addr = $urandom_range(0, 1) ? reg_map[4'($urandom_range(0, 9))] : $urandom;
    send_txn(make_txn(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), addr, $urandom));
  endtask

  // Program both address registers and a length register, then tick the lines
  // out, with the odd register access or rearm in between.
  task automatic dma_burst();
    logic [31:0] mem_word;
    logic [31:0] dram_word;
    logic [11:0] len_field;
    logic [7:0]  count;
    logic [31:0] len_addr;
    int unsigned r;
    int unsigned nticks;
    mem_word = $urandom & 32'hffff_e000;
    mem_word[12] = 1'($urandom_range(0, 1));
    mem_word[11:0] = ($urandom_range(0, 99) < 70) ? 12'($urandom_range(0, 2047))
                                                  : 12'($urandom_range(0, 4095));
    r = $urandom_range(0, 99);
    dram_word = $urandom & 32'hff00_0000;
    if (r < 70) dram_word[23:0] = 24'($urandom_range(0, 32'hffff));
    else if (r < 90) dram_word[23:0] = 24'($urandom_range(32'h3f_f000, 32'h3f_ffff));
    else dram_word[23:0] = 24'($urandom);
    r = $urandom_range(0, 99);
    if (r < 80) len_field = 12'($urandom_range(0, 63));
    else if (r < 95) len_field = 12'($urandom_range(0, 1023));
    else len_field = 12'($urandom_range(0, 4095));
    count = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 5))
                                         : 8'($urandom_range(0, 255));
    len_addr = $urandom_range(0, 1) ? ADDR_WLEN : ADDR_RLEN;

    reg_write(ADDR_MEM, mem_word);
    reg_write(ADDR_DRAM, dram_word);
    reg_write(len_addr, {12'($urandom), count, len_field});
    nticks = ((count < 10) ? count + 1 : 10) + $urandom_range(0, 2);
    repeat (nticks) begin
      r = $urandom_range(0, 99);
      if (r < 12) random_reg_access();
      else if (r < 16) reg_write(len_addr, {12'($urandom), 8'($urandom_range(0, 3)),
                                            12'($urandom_range(0, 127))});
      dma_tick();
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request so that the
  // block backs up and stalls its input while transactions keep being offered.
  initial begin : result_sink
    int unsigned stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_due) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_due = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (no_idle || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_response(out_data);
  end

  // Give up after a generous number of cycles.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned directed_txns;
    int unsigned pick;
    bit          paused_mid;
    in_valid      = 1'b0;
    in_data       = '0;
    rst_n         = 1'b0;
    sent_txns     = 0;
    no_idle       = 1'b0;
    long_hold_due = 1'b0;
    paused_mid    = 1'b0;
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset values, idle ticks, bad sizes, unknown addresses
    reg_read(ADDR_STATUS);
    dma_tick();
    send_txn(make_txn(OP_NONE, WORD_BYTES, ADDR_MEM, 32'hffff_ffff));
    send_txn(make_txn(OP_READ, 4'd0, ADDR_MEM, 32'h0));
    send_txn(make_txn(OP_WRITE, 4'hf, ADDR_BIST, 32'hffff_ffff));
    reg_read(32'hffff_ffff);
    reg_write(32'h0000_0000, 32'hffff_ffff);
    // every status bit at once, set-interrupt included; then the clear bits only
    reg_write(ADDR_STATUS, 32'hffff_ffff);
    reg_read(ADDR_STATUS);
    reg_write(ADDR_STATUS, 32'h00aa_aaad);
    // semaphore: read returns the flag and sets it, write clears it
    reg_read(ADDR_SEMA);
    reg_read(ADDR_SEMA);
    reg_write(ADDR_SEMA, 32'hffff_ffff);
    reg_write(ADDR_PC, 32'hffff_ffff);
    reg_read(ADDR_PC);
    reg_write(ADDR_BIST, 32'ha5a5_5a5a);
    reg_read(ADDR_BIST);
    reg_write(ADDR_BUSY, 32'hffff_ffff);
    reg_read(ADDR_FULL);
    // instruction-memory DMA of 256-byte lines: one line, then local range abort
    reg_write(ADDR_MEM, 32'h0000_1f00);
    reg_write(ADDR_DRAM, 32'h0000_0010);
    reg_write(ADDR_RLEN, 32'h0100_20f8);
    dma_tick();
    dma_tick();
    // largest lines from the top of DRAM: DRAM range abort
    reg_write(ADDR_DRAM, 32'hffff_ffff);
    reg_write(ADDR_WLEN, 32'hffff_ffff);
    dma_tick();
    directed_txns = sent_txns;
    wait_drained();

    // Random: open with a back-to-back burst against a long hold-off
    no_idle       = 1'b1;
    long_hold_due = 1'b1;
    while (sent_txns < directed_txns + RANDOM_TXNS) begin
      if ($urandom_range(0, 99) < 10) no_idle = ~no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 55) dma_burst();
      else if (pick < 80) random_reg_access();
      else noise_txn();
      // halfway: let everything drain, then back up the block once more
      if (!paused_mid && sent_txns >= directed_txns + RANDOM_TXNS / 2) begin
        wait_drained();
        no_idle       = 1'b1;
        long_hold_due = 1'b1;
        paused_mid    = 1'b1;
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (board.failures == 0 && board.awaited_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
